>>> design/resizable_ring_fifo_core_macros.svh
// Assertion helpers for the checker file.
`ifndef RESIZABLE_RING_FIFO_CORE_MACROS_SVH
`define RESIZABLE_RING_FIFO_CORE_MACROS_SVH

// Same-cycle implication, off during reset.
`define RRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define RRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/rrf_pkg.sv
package rrf_pkg;

   localparam logic [1:0] MODE_PUSH   = 2'd0;
   localparam logic [1:0] MODE_POP    = 2'd1;
   localparam logic [1:0] MODE_RESIZE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_BAD_KIND  = 3'd3;
   localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
   localparam logic [2:0] ST_BELOW_LEN = 3'd5;

   // smallest capacity a resize may ask for
   localparam int MIN_SLOTS = 2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         kind;
      logic signed [31:0] count_a;
      logic signed [31:0] count_b;
      logic signed [31:0] count_c;
      logic [5:0]         seats;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         out_kind;
      logic signed [31:0] out_count_a;
      logic signed [31:0] out_count_b;
      logic signed [31:0] out_count_c;
   } rsp_type;

   // one stored record
   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic signed [31:0] third;
   } entry_type;

endpackage

>>> design/rrf_ram.sv
module rrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/resizable_ring_fifo_core.sv
// Resizable ring FIFO of records (kind plus three signed counts). A request is
// taken at a clock edge with start high and busy low; every request gives one
// response, shown for one cycle with rsp_strobe high. The receiver cannot
// stall: a response must be captured in its strobe cycle. Push, a refused
// request, a resize that keeps the size, a resize of an empty queue and the
// unused mode answer in the cycle after the request and leave busy low, so
// such requests may follow back to back. A pop that finds a record reads the
// record memory, whose read is registered: busy is high for one cycle and
// the response is registered from the read data. A resize that changes the
// size of a non-empty queue repacks the live records in order through the
// memory's one read port and one write port, first into a scratch half and
// then back to slot 0 onward, one record per cycle in each pass: busy stays
// high through both passes and the response follows in the next cycle. The
// record memory needs no clearing after reset, so requests are taken right
// away. Capacity resets to START_SLOTS; one slot always stays free.
module resizable_ring_fifo_core #(
   parameter int MAX_SLOTS   = 32,
   parameter int START_SLOTS = 8,
   parameter int KIND_COUNT  = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rrf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rrf_pkg::rsp_type rsp_data
);

   // largest capacity a resize can produce, and the slot range of the live half
   localparam int CAP_TOP    = 1 << $clog2(MAX_SLOTS);
   localparam int SLOT_LIMIT = (CAP_TOP > START_SLOTS) ? CAP_TOP : START_SLOTS;
   localparam int PW         = $clog2(SLOT_LIMIT);       // pointer / length
   localparam int CW         = $clog2(SLOT_LIMIT + 1);   // capacity
   localparam int DEPTH      = 2 * SLOT_LIMIT;           // live half + scratch
   localparam int AW         = $clog2(DEPTH);
   localparam int RW         = (CW > 7) ? CW : 7;        // size request math
   localparam int EW         = $bits(rrf_pkg::entry_type);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;   // live records -> scratch half
   localparam logic [1:0] S_BACK = 2'd3;   // scratch half -> slot 0 onward

   logic [1:0]       state_ff, state_in;
   logic [PW-1:0]    rp_ff, rp_in;
   logic [PW-1:0]    wp_ff, wp_in;
   logic [CW-1:0]    cap_ff, cap_in;
   logic [CW-1:0]    new_cap_ff, new_cap_in;
   logic [PW-1:0]    len_ff, len_in;
   logic [PW-1:0]    src_ff, src_in;
   logic [PW-1:0]    mv_cnt_ff, mv_cnt_in;
   logic             pipe_vld_ff, pipe_vld_in;
   logic [AW-1:0]    pipe_addr_ff, pipe_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rrf_pkg::rsp_type rsp_ff, rsp_in;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   rrf_pkg::entry_type ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   rrf_pkg::entry_type ram_rd_data;

   logic          accept;
   logic [CW-1:0] diff_w;
   logic [PW-1:0] len_w;
   logic          full_w;
   logic          empty_w;
   logic          kind_ok_w;
   logic [RW-1:0] req_sz_w;
   logic [RW-1:0] round_w;
   logic          size_bad_w;
   logic          below_w;
   logic [CW-1:0] new_cap_w;

   // pointer step with wrap at the given capacity
   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr,
                                              input logic [CW-1:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(ptr) + CW'(1);
      return (nxt == cap) ? '0 : nxt[PW-1:0];
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // live record count and request checks
   always_comb begin
      if (wp_ff >= rp_ff) begin
         diff_w = CW'(wp_ff) - CW'(rp_ff);
      end else begin
         diff_w = cap_ff + CW'(wp_ff) - CW'(rp_ff);
      end
      len_w     = diff_w[PW-1:0];
      full_w    = (CW'(len_w) == cap_ff - CW'(1));
      empty_w   = (rp_ff == wp_ff);
      kind_ok_w = (req_data.kind != 4'd0) && (32'(req_data.kind) <= KIND_COUNT);

      req_sz_w   = RW'(req_data.seats) + RW'(1);
      size_bad_w = (req_sz_w < RW'(rrf_pkg::MIN_SLOTS)) || (req_sz_w > RW'(MAX_SLOTS));
      below_w    = (req_sz_w < RW'(cap_ff)) && (req_sz_w <= RW'(len_w));

      // round the request up to a power of two
      round_w = RW'(1);
      for (int i = 0; i < RW; i++) begin
         if (round_w < req_sz_w) begin
            round_w = round_w << 1;
         end
      end
      new_cap_w = round_w[CW-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      cap_in       = cap_ff;
      new_cap_in   = new_cap_ff;
      len_in       = len_ff;
      src_in       = src_ff;
      mv_cnt_in    = mv_cnt_ff;
      pipe_vld_in  = 1'b0;
      pipe_addr_in = pipe_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      ram_rd_addr  = AW'(rp_ff);
      // relocation write follows its read in the next cycle
      ram_wr_en    = pipe_vld_ff;
      ram_wr_addr  = pipe_addr_ff;
      ram_wr_data  = ram_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  rrf_pkg::MODE_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (full_w) begin
                        rsp_in.status = rrf_pkg::ST_FULL;
                     end else if (!kind_ok_w) begin
                        rsp_in.status = rrf_pkg::ST_BAD_KIND;
                     end else begin
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = AW'(wp_ff);
                        ram_wr_data.kind   = req_data.kind[2:0];
                        ram_wr_data.first  = req_data.count_a;
                        ram_wr_data.second = req_data.count_b;
                        ram_wr_data.third  = req_data.count_c;
                        wp_in              = wrap_inc(wp_ff, cap_ff);
                     end
                  end
                  rrf_pkg::MODE_POP: begin
                     if (empty_w) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = rrf_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  rrf_pkg::MODE_RESIZE: begin
                     if (size_bad_w) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = rrf_pkg::ST_BAD_SIZE;
                     end else if (below_w) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = rrf_pkg::ST_BELOW_LEN;
                     end else if (new_cap_w == cap_ff) begin
                        rsp_valid_in = 1'b1;
                     end else if (empty_w) begin
                        rsp_valid_in = 1'b1;
                        cap_in       = new_cap_w;
                        rp_in        = '0;
                        wp_in        = '0;
                     end else begin
                        new_cap_in = new_cap_w;
                        len_in     = len_w;
                        src_in     = rp_ff;
                        mv_cnt_in  = '0;
                        state_in   = S_OUT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.out_kind    = ram_rd_data.kind;
            rsp_in.out_count_a = ram_rd_data.first;
            rsp_in.out_count_b = ram_rd_data.second;
            rsp_in.out_count_c = ram_rd_data.third;
            rp_in              = wrap_inc(rp_ff, cap_ff);
            state_in           = S_IDLE;
         end
         S_OUT: begin
            if (mv_cnt_ff < len_ff) begin
               ram_rd_addr  = AW'(src_ff);
               src_in       = wrap_inc(src_ff, cap_ff);
               pipe_vld_in  = 1'b1;
               pipe_addr_in = AW'(SLOT_LIMIT) + AW'(mv_cnt_ff);
               mv_cnt_in    = mv_cnt_ff + PW'(1);
            end else begin
               mv_cnt_in = '0;
               state_in  = S_BACK;
            end
         end
         S_BACK: begin
            if (mv_cnt_ff < len_ff) begin
               ram_rd_addr  = AW'(SLOT_LIMIT) + AW'(mv_cnt_ff);
               pipe_vld_in  = 1'b1;
               pipe_addr_in = AW'(mv_cnt_ff);
               mv_cnt_in    = mv_cnt_ff + PW'(1);
            end else begin
               cap_in       = new_cap_ff;
               rp_in        = '0;
               wp_in        = len_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         cap_ff       <= CW'(START_SLOTS);
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         cap_ff       <= cap_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_cap_ff   <= new_cap_in;
      len_ff       <= len_in;
      src_ff       <= src_in;
      mv_cnt_ff    <= mv_cnt_in;
      pipe_addr_ff <= pipe_addr_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   rrf_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> design/rrf_checker.sv
`include "resizable_ring_fifo_core_macros.svh"

module rrf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input rrf_pkg::req_type req_data,
   input logic             rsp_strobe,
   input rrf_pkg::rsp_type rsp_data
);

   logic push_acc;
   logic pop_acc;

   assign push_acc = start && !busy && (req_data.mode == rrf_pkg::MODE_PUSH);
   assign pop_acc  = start && !busy && (req_data.mode == rrf_pkg::MODE_POP);

   `RRF_ASSERT_NEXT(a_push_answers, clock, reset, push_acc, rsp_strobe && !busy, "push not answered next cycle")

   `RRF_ASSERT_NEXT(a_pop_flow, clock, reset, pop_acc, busy != rsp_strobe, "pop neither answered nor reading")

   `RRF_ASSERT_NOW(a_fail_zero, clock, reset, rsp_strobe && (rsp_data.status != rrf_pkg::ST_OK), (rsp_data.out_kind == 3'd0) && (rsp_data.out_count_a == 32'sd0) && (rsp_data.out_count_b == 32'sd0) && (rsp_data.out_count_c == 32'sd0), "refused request carries record data")

   `RRF_ASSERT_NOW(a_status_code, clock, reset, rsp_strobe, rsp_data.status <= rrf_pkg::ST_BELOW_LEN, "unknown status code")

endmodule

bind resizable_ring_fifo_core rrf_checker u_rrf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

>>> verif/resizable_ring_fifo_core_tb.sv
module resizable_ring_fifo_core_tb;

   // Build of the block under test; the predictor follows the same numbers.
   localparam int MAX_SLOTS   = 32;
   localparam int START_SLOTS = 8;
   localparam int KIND_COUNT  = 5;

   // Mode 3 has no meaning in the block: answered with status ok, zero fields.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic signed [31:0] CNT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] CNT_MAX = 32'sh7FFF_FFFF;

   localparam int ITEMS_PER_PHASE = 250;
   localparam int DRAIN_CYCLES    = 8;

   // One line of the directed part. When known is set, answer is the typed-in
   // expectation; otherwise the predictor supplies it.
   typedef struct {
      rrf_pkg::req_type cmd;
      bit               known;
      rrf_pkg::rsp_type answer;
   } plan_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   rrf_pkg::req_type req_data;
   logic             rsp_strobe;
   rrf_pkg::rsp_type rsp_data;

   // Predictor state: ring of records, head/tail slots and present capacity.
   rrf_pkg::entry_type ring_slots [MAX_SLOTS];
   int unsigned        ring_head;
   int unsigned        ring_tail;
   int unsigned        ring_cap;

   // Responses owed by the block, oldest first.
   rrf_pkg::rsp_type awaited_answers [$];

   int mismatch_count;
   int mode_tally [4];
   int status_tally [8];
   int capacity_changes;

   plan_row_type directed_plan [0:25];

   resizable_ring_fifo_core #(
      .MAX_SLOTS  (MAX_SLOTS),
      .START_SLOTS(START_SLOTS),
      .KIND_COUNT (KIND_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic rrf_pkg::req_type cmd(logic [1:0] mode, logic [3:0] kind,
                                            logic signed [31:0] a, logic signed [31:0] b,
                                            logic signed [31:0] c, logic [5:0] seats);
      rrf_pkg::req_type r;
      r.mode    = mode;
      r.kind    = kind;
      r.count_a = a;
      r.count_b = b;
      r.count_c = c;
      r.seats   = seats;
      return r;
   endfunction

   function automatic rrf_pkg::rsp_type ans(logic [2:0] status, logic [2:0] kind,
                                            logic signed [31:0] a, logic signed [31:0] b,
                                            logic signed [31:0] c);
      rrf_pkg::rsp_type p;
      p.status      = status;
      p.out_kind    = kind;
      p.out_count_a = a;
      p.out_count_b = b;
      p.out_count_c = c;
      return p;
   endfunction

   // Works out the response to one accepted request and moves the ring state.
   function automatic rrf_pkg::rsp_type predict_fifo_answer(rrf_pkg::req_type r);
      rrf_pkg::rsp_type   a;
      int unsigned        fill;
      int unsigned        want;
      int unsigned        grown;
      rrf_pkg::entry_type moved [MAX_SLOTS];
      a    = '0;
      fill = (ring_cap + ring_tail - ring_head) % ring_cap;
      case (r.mode)
         rrf_pkg::MODE_PUSH: begin
            // full wins over a bad kind
            if (fill == ring_cap - 1)
               a.status = rrf_pkg::ST_FULL;
            else if (r.kind < 1 || r.kind > KIND_COUNT)
               a.status = rrf_pkg::ST_BAD_KIND;
            else begin
               ring_slots[ring_tail] = '{r.kind[2:0], r.count_a, r.count_b, r.count_c};
               ring_tail = (ring_tail + 1) % ring_cap;
            end
         end
         rrf_pkg::MODE_POP: begin
            if (ring_head == ring_tail)
               a.status = rrf_pkg::ST_EMPTY;
            else begin
               a.out_kind    = ring_slots[ring_head].kind;
               a.out_count_a = ring_slots[ring_head].first;
               a.out_count_b = ring_slots[ring_head].second;
               a.out_count_c = ring_slots[ring_head].third;
               ring_head = (ring_head + 1) % ring_cap;
            end
         end
         rrf_pkg::MODE_RESIZE: begin
            want = r.seats + 1;
            if (want < rrf_pkg::MIN_SLOTS || want > MAX_SLOTS)
               a.status = rrf_pkg::ST_BAD_SIZE;
            else if (want < ring_cap && want <= fill)
               a.status = rrf_pkg::ST_BELOW_LEN;
            else begin
               grown = 1;
               while (grown < want) grown = grown << 1;
               // same size: nothing moves
               if (grown != ring_cap) begin
                  for (int i = 0; i < fill; i++)
                     moved[i] = ring_slots[(ring_head + i) % ring_cap];
                  for (int i = 0; i < fill; i++)
                     ring_slots[i] = moved[i];
                  ring_cap  = grown;
                  ring_head = 0;
                  ring_tail = fill;
                  capacity_changes++;
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic signed [31:0] random_count();
      case ($urandom_range(15))
         0:       return CNT_MIN;
         1:       return CNT_MAX;
         2:       return 32'sd0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly pushes and pops with a tunable lean, so the ring swings between
   // empty and full; resizes and the spare mode mixed in.
   function automatic rrf_pkg::req_type random_request(int push_bias);
      rrf_pkg::req_type r;
      int               roll;
      roll = $urandom_range(99);
      if (roll < 3)
         r.mode = MODE_SPARE;
      else if (roll < 13)
         r.mode = rrf_pkg::MODE_RESIZE;
      else if ($urandom_range(99) < push_bias)
         r.mode = rrf_pkg::MODE_PUSH;
      else
         r.mode = rrf_pkg::MODE_POP;
      r.kind = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                         : 4'($urandom_range(KIND_COUNT, 1));
      r.count_a = random_count();
      r.count_b = random_count();
      r.count_c = random_count();
      r.seats = ($urandom_range(5) == 0) ? 6'($urandom_range(63))
                                          : 6'($urandom_range(MAX_SLOTS - 1, 1));
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Holds the request until start meets busy low, then books the expectation.
   task automatic issue_request(rrf_pkg::req_type r, bit known, rrf_pkg::rsp_type typed);
      rrf_pkg::rsp_type predicted;
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_fifo_answer(r);
      awaited_answers.push_back(known ? typed : predicted);
      mode_tally[r.mode]++;
      status_tally[predicted.status]++;
   endtask

   // Sender gap: each cycle idles with the given odds, with noise on the bus.
   task automatic hold_off(int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_data <= random_request(50);
         @(posedge clock);
      end
   endtask

   // Response checker: every strobe must match the oldest booked answer.
   always @(posedge clock) begin
      rrf_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_answers.size() == 0)
            flag_mismatch("response with no request outstanding");
         else begin
            want = awaited_answers.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch($sformatf("status %0d, want %0d",
                                       rsp_data.status, want.status));
            if (rsp_data.out_kind !== want.out_kind)
               flag_mismatch($sformatf("out_kind %0d, want %0d",
                                       rsp_data.out_kind, want.out_kind));
            if (rsp_data.out_count_a !== want.out_count_a)
               flag_mismatch($sformatf("out_count_a %0d, want %0d",
                                       rsp_data.out_count_a, want.out_count_a));
            if (rsp_data.out_count_b !== want.out_count_b)
               flag_mismatch($sformatf("out_count_b %0d, want %0d",
                                       rsp_data.out_count_b, want.out_count_b));
            if (rsp_data.out_count_c !== want.out_count_c)
               flag_mismatch($sformatf("out_count_c %0d, want %0d",
                                       rsp_data.out_count_c, want.out_count_c));
         end
      end
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int               idle_by_phase [4];
      int               done_here;
      int               counted;
      int               push_bias;
      rrf_pkg::req_type r;

      idle_by_phase    = '{0, 73, 0, 19};
      mismatch_count   = 0;
      capacity_changes = 0;
      counted          = 0;
      mode_tally       = '{default: 0};
      status_tally     = '{default: 0};
      ring_head        = 0;
      ring_tail        = 0;
      ring_cap         = START_SLOTS;

      // Directed part. Typed answers only where obvious; the rest predicted.
      // Opening rows run from reset (capacity 8, empty).
      directed_plan = '{
         // pop of an empty queue
         '{cmd(rrf_pkg::MODE_POP, 4'd0, 0, 0, 0, 6'd0), 1'b1,
           ans(rrf_pkg::ST_EMPTY, 0, 0, 0, 0)},
         // kinds outside the valid range, both ends
         '{cmd(rrf_pkg::MODE_PUSH, 4'd0, 1, 2, 3, 6'd0), 1'b1,
           ans(rrf_pkg::ST_BAD_KIND, 0, 0, 0, 0)},
         '{cmd(rrf_pkg::MODE_PUSH, 4'd15, 1, 2, 3, 6'd0), 1'b1,
           ans(rrf_pkg::ST_BAD_KIND, 0, 0, 0, 0)},
         // lowest and highest kind with extreme counts
         '{cmd(rrf_pkg::MODE_PUSH, 4'd1, CNT_MIN, CNT_MAX, -1, 6'd0), 1'b1,
           ans(rrf_pkg::ST_OK, 0, 0, 0, 0)},
         '{cmd(rrf_pkg::MODE_PUSH, 4'd5, CNT_MAX, 0, CNT_MIN, 6'd0), 1'b1,
           ans(rrf_pkg::ST_OK, 0, 0, 0, 0)},
         '{cmd(rrf_pkg::MODE_POP, 4'd0, 0, 0, 0, 6'd0), 1'b1,
           ans(rrf_pkg::ST_OK, 3'd1, CNT_MIN, CNT_MAX, -1)},
         // sizes out of range: too small, top code, just over the maximum
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd0), 1'b1,
           ans(rrf_pkg::ST_BAD_SIZE, 0, 0, 0, 0)},
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd63), 1'b1,
           ans(rrf_pkg::ST_BAD_SIZE, 0, 0, 0, 0)},
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd32), 1'b1,
           ans(rrf_pkg::ST_BAD_SIZE, 0, 0, 0, 0)},
         // unused mode with every field bit set
         '{cmd(MODE_SPARE, 4'd15, -1, -1, -1, 6'd63), 1'b1,
           ans(rrf_pkg::ST_OK, 0, 0, 0, 0)},
         '{cmd(rrf_pkg::MODE_PUSH, 4'd2, 32'sh1234_5678, -7, 99, 6'd0), 1'b0, '0},
         '{cmd(rrf_pkg::MODE_PUSH, 4'd3, -5, 32'sh0F0F_0F0F, 0, 6'd0), 1'b0, '0},
         // three live records: shrinking to 2 or 3 would drop some
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd1), 1'b1,
           ans(rrf_pkg::ST_BELOW_LEN, 0, 0, 0, 0)},
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd2), 1'b1,
           ans(rrf_pkg::ST_BELOW_LEN, 0, 0, 0, 0)},
         // shrink to 4 leaves the ring full
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd3), 1'b0, '0},
         '{cmd(rrf_pkg::MODE_PUSH, 4'd4, 11, 22, 33, 6'd0), 1'b0, '0},
         // full takes priority over a bad kind
         '{cmd(rrf_pkg::MODE_PUSH, 4'd0, 11, 22, 33, 6'd0), 1'b0, '0},
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd7), 1'b0, '0},
         // rounds to the present size: no-op
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd6), 1'b0, '0},
         '{cmd(rrf_pkg::MODE_PUSH, 4'd4, CNT_MAX, CNT_MIN, 1, 6'd0), 1'b0, '0},
         // largest capacity
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd31), 1'b0, '0},
         // order must survive every move
         '{cmd(rrf_pkg::MODE_POP, 4'd0, 0, 0, 0, 6'd0), 1'b0, '0},
         '{cmd(rrf_pkg::MODE_POP, 4'd0, 0, 0, 0, 6'd0), 1'b0, '0},
         '{cmd(rrf_pkg::MODE_POP, 4'd0, 0, 0, 0, 6'd0), 1'b0, '0},
         '{cmd(rrf_pkg::MODE_POP, 4'd0, 0, 0, 0, 6'd0), 1'b0, '0},
         // smallest capacity, empty queue
         '{cmd(rrf_pkg::MODE_RESIZE, 4'd0, 0, 0, 0, 6'd1), 1'b0, '0}
      };

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i])
         issue_request(directed_plan[i].cmd, directed_plan[i].known,
                       directed_plan[i].answer);

      // Random part: four phases with their own idle odds; spare-mode requests are not counted.
      // The push lean flips every 40 requests so the ring fills and drains.
      for (int phase = 0; phase < 4; phase++) begin
         done_here = 0;
         while (done_here < ITEMS_PER_PHASE) begin
            push_bias = ((counted / 40) % 2 == 0) ? 75 : 30;
            r = random_request(push_bias);
            issue_request(r, 1'b0, '0);
            if (r.mode != MODE_SPARE) begin
               done_here++;
               counted++;
            end
            hold_off(idle_by_phase[phase]);
         end
      end
      start <= 1'b0;

      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d push, %0d pop, %0d resize, %0d unused mode;",
               mode_tally[0] + mode_tally[1] + mode_tally[2] + mode_tally[3],
               mode_tally[rrf_pkg::MODE_PUSH], mode_tally[rrf_pkg::MODE_POP],
               mode_tally[rrf_pkg::MODE_RESIZE], mode_tally[MODE_SPARE]);
      $display("%0d capacity changes; refused: full %0d, empty %0d, kind %0d, size %0d, len %0d",
               capacity_changes, status_tally[rrf_pkg::ST_FULL],
               status_tally[rrf_pkg::ST_EMPTY], status_tally[rrf_pkg::ST_BAD_KIND],
               status_tally[rrf_pkg::ST_BAD_SIZE], status_tally[rrf_pkg::ST_BELOW_LEN]);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
